// ----- hdl/hfit_pkg.sv -----
// Shared types and constants for the find-or-insert hash table.
package hfit_pkg;

    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

    localparam int unsigned MIX_SHIFT_1 = 30;
    localparam int unsigned MIX_SHIFT_2 = 27;
    localparam int unsigned MIX_SHIFT_3 = 31;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned VALUE_W = 32;

    localparam int unsigned RED_BITS  = 8;
    localparam int unsigned RED_CNT_W = 3;
    localparam logic [RED_CNT_W-1:0] RED_CNT_LAST = RED_CNT_W'(KEY_W / RED_BITS - 1);

    typedef enum logic [1:0] {
        MUL_LO_LO = 2'd0,
        MUL_HI_LO = 2'd1,
        MUL_LO_HI = 2'd2
    } hfit_mul_step_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_HASH   = 3'd2,
        ST_REDUCE = 3'd3,
        ST_READ   = 3'd4,
        ST_CHECK  = 3'd5
    } hfit_state_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } hfit_slot_t;

endpackage

// ----- hdl/hfit_mix.sv -----
// 64-bit mixing hash over a shared 32x32 multiplier, three partial products per multiply.
module hfit_mix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] hash
);
    import hfit_pkg::*;

    logic           busy_reg;
    logic           round_reg;
    hfit_mul_step_t step_reg;
    logic           done_reg;
    logic [63:0]    v_reg;
    logic [63:0]    acc_reg;
    logic [63:0]    hash_reg;

    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [31:0] sum_hi;
    logic [63:0] acc_next;

    always_comb
    begin
        mul_const = round_reg ? MIX_MUL_B : MIX_MUL_A;
        case (step_reg)
            MUL_LO_LO:
            begin
                mul_a = v_reg[31:0];
                mul_b = mul_const[31:0];
            end
            MUL_HI_LO:
            begin
                mul_a = v_reg[63:32];
                mul_b = mul_const[31:0];
            end
            MUL_LO_HI:
            begin
                mul_a = v_reg[31:0];
                mul_b = mul_const[63:32];
            end
            default:
            begin
                mul_a = v_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
        prod     = {32'd0, mul_a} * {32'd0, mul_b};
        sum_hi   = acc_reg[63:32] + prod[31:0];
        acc_next = (step_reg == MUL_LO_LO) ? prod : {sum_hi, acc_reg[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 1'b0;
            step_reg  <= MUL_LO_LO;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && round_reg && (step_reg == MUL_LO_HI);
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 1'b0;
                step_reg  <= MUL_LO_LO;
            end
            else if (busy_reg)
            begin
                case (step_reg)
                    MUL_LO_LO: step_reg <= MUL_HI_LO;
                    MUL_HI_LO: step_reg <= MUL_LO_HI;
                    default:
                    begin
                        step_reg  <= MUL_LO_LO;
                        round_reg <= 1'b1;
                        if (round_reg)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= key ^ (key >> MIX_SHIFT_1);
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            if (step_reg == MUL_LO_HI)
            begin
                if (round_reg)
                begin
                    hash_reg <= acc_next ^ (acc_next >> MIX_SHIFT_3);
                end
                else
                begin
                    v_reg <= acc_next ^ (acc_next >> MIX_SHIFT_2);
                end
            end
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

// ----- hdl/hash_find_or_insert_table.sv -----
// Top level of the find-or-insert hash table with linear probing.
//
// Input channel: lookup_key and new_value move on a transfer with in_valid high and
// in_stall low. Output channel: found_value, was_inserted and table_full move on a
// transfer with out_valid high and out_stall low. Every input transfer yields
// exactly one output transfer, in order.
// After reset the block sweeps the slot memory once to clear the valid bits; in_stall
// stays high during the sweep.
// One item at a time. The hash runs on one shared 32x32 multiplier (three partial
// products per multiply); each probe is a read and a compare on the single slot
// memory. When TABLE_SLOTS is not a power of two, an extra reduce step turns the
// hash into a slot.
// The result sits in an output register; the block takes the next item while it
// waits. If the receiver still stalls when the next result is ready, the block
// holds in the compare step until the output register frees.
module hash_find_or_insert_table #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] lookup_key,
    input  logic [31:0] new_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] found_value,
    output logic        was_inserted,
    output logic        table_full
);
    import hfit_pkg::*;

    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int FILL_LIMIT  = TABLE_SLOTS / 2;
    localparam int FILL_W      = $clog2(FILL_LIMIT + 1);
    localparam bit POW2        = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FILL_LIMIT);

    hfit_state_t state_reg;
    hfit_state_t state_next;

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [IDX_W-1:0]   clr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [IDX_W-1:0]   rem_reg;
    logic [63:0]        hash_sh_reg;
    logic [RED_CNT_W-1:0] red_cnt_reg;
    hfit_slot_t         rd_data_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] found_value_reg;
    logic               was_inserted_reg;
    logic               table_full_reg;

    hfit_slot_t slot_mem [TABLE_SLOTS];

    logic               mix_start;
    logic               mix_done;
    logic [63:0]        mix_hash;

    logic               out_free;
    logic               hit;
    logic               empty;
    logic               full;
    logic               out_load;
    logic [VALUE_W-1:0] res_value;
    logic               res_inserted;
    logic               res_full;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    hfit_slot_t         wr_data;
    logic               fill_inc;
    logic [IDX_W-1:0]   rem_step;
    logic [IDX_W-1:0]   pos_wrap;

    hfit_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .key   (lookup_key),
        .done  (mix_done),
        .hash  (mix_hash)
    );

    // Fold eight hash bits per cycle into the running remainder, most significant first.
    always_comb
    begin
        logic [IDX_W-1:0] r;
        logic [IDX_W:0]   t;
        r = rem_reg;
        for (int i = 0; i < RED_BITS; i++)
        begin
            t = {r, hash_sh_reg[63 - i]};
            if (t >= SLOTS_EXT)
            begin
                t = t - SLOTS_EXT;
            end
            r = t[IDX_W-1:0];
        end
        rem_step = r;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign hit      = rd_data_reg.valid && (rd_data_reg.key == key_reg);
    assign empty    = !rd_data_reg.valid;
    assign full     = fill_reg >= FILL_MAX;
    assign pos_wrap = (pos_reg == LAST_POS) ? '0 : pos_reg + IDX_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_POS)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mix_done)
                begin
                    state_next = POW2 ? ST_READ : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (red_cnt_reg == RED_CNT_LAST)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit || empty)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        mix_start     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data.valid = 1'b1;
        wr_data.key   = key_reg;
        wr_data.value = value_reg;
        out_load      = 1'b0;
        res_value     = '0;
        res_inserted  = 1'b0;
        res_full      = 1'b0;
        fill_inc      = 1'b0;
        pos_next      = pos_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_reg;
                wr_data.valid = 1'b0;
            end
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                mix_start = in_valid;
            end
            ST_HASH:
            begin
                if (mix_done)
                begin
                    pos_next = mix_hash[IDX_W-1:0];
                end
            end
            ST_REDUCE:
            begin
                if (red_cnt_reg == RED_CNT_LAST)
                begin
                    pos_next = rem_step;
                end
            end
            ST_READ:
            begin
                pos_next = pos_reg;
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    out_load  = out_free;
                    res_value = rd_data_reg.value;
                end
                else if (empty)
                begin
                    out_load = out_free;
                    if (full)
                    begin
                        res_full = 1'b1;
                    end
                    else
                    begin
                        res_value    = value_reg;
                        res_inserted = 1'b1;
                        wr_en        = out_free;
                        fill_inc     = out_free;
                    end
                end
                else
                begin
                    pos_next = pos_wrap;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            fill_reg      <= '0;
            red_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (fill_inc)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (state_reg == ST_REDUCE)
            begin
                red_cnt_reg <= red_cnt_reg + RED_CNT_W'(1);
            end
            else
            begin
                red_cnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (mix_start)
        begin
            key_reg   <= lookup_key;
            value_reg <= new_value;
        end
        if (state_reg == ST_HASH)
        begin
            hash_sh_reg <= mix_hash;
            rem_reg     <= '0;
        end
        else if (state_reg == ST_REDUCE)
        begin
            hash_sh_reg <= hash_sh_reg << RED_BITS;
            rem_reg     <= rem_step;
        end
        if (out_load)
        begin
            found_value_reg  <= res_value;
            was_inserted_reg <= res_inserted;
            table_full_reg   <= res_full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[pos_reg];
    end

    assign out_valid    = out_valid_reg;
    assign found_value  = found_value_reg;
    assign was_inserted = was_inserted_reg;
    assign table_full   = table_full_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count above load limit");

    a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && wr_en) |=> (out_valid && was_inserted && !table_full))
        else $error("slot write without an inserted result");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_inserted && table_full))
        else $error("inserted and full flagged together");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !hit && !empty) |=> (state_reg == ST_READ && in_stall))
        else $error("probe did not advance");
`endif

endmodule

// ----- sim/hash_find_or_insert_table_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the find-or-insert hash table with linear probing.
module hash_find_or_insert_table_tb;

    import hfit_pkg::*;

    localparam int unsigned SLOTS       = 1024;
    localparam int unsigned QUIET_LIMIT = 6000;
    localparam int unsigned DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } lookup_request_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               inserted;
        logic               full;
    } lookup_result_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [KEY_W-1:0]   lookup_key   = '0;
    logic [VALUE_W-1:0] new_value    = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [VALUE_W-1:0] found_value;
    logic               was_inserted;
    logic               table_full;

    lookup_request_t queued_requests[$];
    lookup_result_t  expected_lookups[$];

    logic               tab_used [SLOTS];
    logic [KEY_W-1:0]   tab_key  [SLOTS];
    logic [VALUE_W-1:0] tab_val  [SLOTS];
    int unsigned        tab_fill;

    int unsigned item_total;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned faults;
    int unsigned quiet_cycles;
    lookup_request_t next_req;
    lookup_result_t  want;

    hash_find_or_insert_table #(
        .TABLE_SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .lookup_key(lookup_key),
        .new_value(new_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found_value(found_value),
        .was_inserted(was_inserted),
        .table_full(table_full)
    );

    always #6 clk = ~clk;

    function automatic int unsigned home_slot(logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] h;
        h = key;
        h = h ^ (h >> MIX_SHIFT_1);
        h = h * MIX_MUL_A;
        h = h ^ (h >> MIX_SHIFT_2);
        h = h * MIX_MUL_B;
        h = h ^ (h >> MIX_SHIFT_3);
        return int'(h % 64'(SLOTS));
    endfunction

    function automatic lookup_result_t find_or_insert(logic [KEY_W-1:0] key,
                                                      logic [VALUE_W-1:0] cand);
        lookup_result_t r;
        int unsigned    pos;
        int unsigned    probes;
        bit             settled;
        r       = '{value: '0, inserted: 1'b0, full: 1'b1};
        pos     = home_slot(key);
        settled = 1'b0;
        for (probes = 0; probes < SLOTS && !settled; probes++)
        begin
            if (tab_used[pos])
            begin
                if (tab_key[pos] == key)
                begin
                    r       = '{value: tab_val[pos], inserted: 1'b0, full: 1'b0};
                    settled = 1'b1;
                end
            end
            else
            begin
                settled = 1'b1;
                if ((tab_fill + 1) * 2 <= SLOTS)
                begin
                    tab_used[pos] = 1'b1;
                    tab_key[pos]  = key;
                    tab_val[pos]  = cand;
                    tab_fill++;
                    r = '{value: cand, inserted: 1'b1, full: 1'b0};
                end
            end
            pos = (pos + 1) % SLOTS;
        end
        return r;
    endfunction

    function automatic int unsigned idle_rate(int unsigned done_count);
        int unsigned rates[3];
        rates = '{0, 10, 35};
        if (done_count + 150 >= item_total)
            return 0;
        return rates[(done_count / 120) % 3];
    endfunction

    function automatic void add_request(logic [KEY_W-1:0] req_key,
                                        logic [VALUE_W-1:0] req_value);
        queued_requests.insert(queued_requests.size(), '{key: req_key, value: req_value});
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            lookup_key <= '0;
            new_value  <= '0;
            send_gap   = 0;
            items_sent = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (queued_requests.size() != 0 &&
                     $urandom_range(0, 99) < idle_rate(items_sent))
            begin
                send_gap = $urandom_range(0, 18);
                in_valid <= 1'b0;
            end
            else if (queued_requests.size() != 0)
            begin
                next_req = queued_requests.pop_front();
                lookup_key <= next_req.key;
                new_value  <= next_req.value;
                in_valid   <= 1'b1;
                items_sent++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_left   = 0;
            hold_left    = 0;
            hold_done    = 1'b0;
            results_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_lookups.insert(expected_lookups.size(),
                                        find_or_insert(lookup_key, new_value));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_lookups.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected result: value %h inserted %b full %b",
                                 found_value, was_inserted, table_full);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (found_value !== want.value || was_inserted !== want.inserted ||
                        table_full !== want.full)
                    begin
                        faults++;
                        if (faults <= 10)
                            $display("result %0d: expected value %h inserted %b full %b, got value %h inserted %b full %b",
                                     results_seen, want.value, want.inserted, want.full,
                                     found_value, was_inserted, table_full);
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 299;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < idle_rate(results_seen))
            begin
                stall_left = $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_W-1:0]   used_keys[$];
        logic [KEY_W-1:0]   near_zero[$];
        logic [KEY_W-1:0]   at_end[$];
        logic [KEY_W-1:0]   k;
        logic [KEY_W-1:0]   key;
        int unsigned        pick;
        int unsigned        n;

        faults = 0;
        for (n = 0; n < SLOTS; n++)
        begin
            tab_used[n] = 1'b0;
            tab_key[n]  = '0;
            tab_val[n]  = '0;
        end
        tab_fill = 0;

        for (k = 1; near_zero.size() < 2; k++)
            if (home_slot(k) == home_slot('0))
                near_zero.insert(near_zero.size(), k);
        for (k = 64'd1000000; at_end.size() < 2; k++)
            if (home_slot(k) == SLOTS - 1)
                at_end.insert(at_end.size(), k);

        // extremes, probe chains from a shared home slot, and wrap past the last slot
        add_request('0,                        '0);
        add_request('0,                        '1);
        add_request(near_zero[0],              32'd1);
        add_request(near_zero[1],              32'd2);
        add_request(near_zero[1],              32'd3);
        add_request('1,                        '1);
        add_request('1,                        '0);
        add_request(64'd1,                     32'h80000000);
        add_request(64'h8000000000000000,      32'h7fffffff);
        add_request(64'h5555555555555555,      32'h55555555);
        add_request(64'haaaaaaaaaaaaaaaa,      32'haaaaaaaa);
        add_request(at_end[0],                 32'd10);
        add_request(at_end[1],                 32'd11);
        add_request(at_end[1],                 32'd12);
        add_request(64'd1,                     32'd0);
        add_request(64'h00000000ffffffff,      32'h0000ffff);
        add_request(64'hffffffff00000000,      32'hffff0000);
        used_keys = '{'0, '1, 64'd1, near_zero[0], near_zero[1], at_end[0], at_end[1]};

        // random part: fresh keys fill the table past its load limit, repeats hit
        for (n = 0; n < 1433; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                key = {$urandom, $urandom};
            else if (pick < 85)
                key = used_keys[$urandom_range(0, used_keys.size() - 1)];
            else if (pick < 93)
                key = 64'($urandom_range(0, 4095));
            else
                key = ~64'($urandom_range(0, 4095));
            if (pick < 50 || pick >= 85)
                used_keys.insert(used_keys.size(), key);
            add_request(key, $urandom);
        end
        item_total = queued_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || in_valid || expected_lookups.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (expected_lookups.size() != 0)
        begin
            faults += expected_lookups.size();
            $display("%0d expected results never arrived", expected_lookups.size());
        end
        if (faults == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- hash_find_or_insert_table.f -----
hdl/hfit_pkg.sv
hdl/hfit_mix.sv
hdl/hash_find_or_insert_table.sv
sim/hash_find_or_insert_table_tb.sv
